### sv/sos_pkg.sv
// Shared types and constants for the sweep object segmenter.
package sos_pkg;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_MAX_RANGE  = 2'd0,
		REG_NEAR_TOL   = 2'd1,
		REG_FAR_TOL    = 2'd2,
		REG_MIN_RUN    = 2'd3
	} reg_idx_t;

	// Result kinds
	localparam logic KIND_OBJECT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Register reset values
	localparam logic [15:0] MAX_RANGE_RST = 16'd4000;
	localparam logic [15:0] NEAR_TOL_RST  = 16'd48;
	localparam logic [15:0] FAR_TOL_RST   = 16'd64;
	localparam logic [7:0]  MIN_RUN_RST   = 8'd7;

	// Run length saturates here so that width stays within 8 bits
	localparam logic [7:0] RUN_CAP = 8'd254;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Work for the back end: an object report, a summary, or both
	typedef struct packed {
		logic        has_rep;
		logic        has_sum;
		logic [6:0]  rep_number;
		logic [7:0]  rep_angle;
		logic [15:0] rep_distance;
		logic [7:0]  rep_width;
		logic [7:0]  sum_angle;
		logic [15:0] sum_distance;
		logic [7:0]  sum_width;
	} work_t;

endpackage

### sv/sos_front.sv
// Front end: configuration registers, reading classification and sweep state.
module sos_front #(
	parameter int SWEEP_POINTS = 181
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 accept,
	input  logic [15:0]          distance,
	input  logic [7:0]           angle,
	input  logic                 end_of_sweep,
	output logic                 push,
	output sos_pkg::work_t       work
);
	import sos_pkg::*;

	localparam logic [7:0] SweepW = 8'(SWEEP_POINTS);

	logic [15:0] max_range_q, near_tol_q, far_tol_q;
	logic [7:0]  min_run_q;

	logic        in_object_q;
	logic [7:0]  run_length_q;
	logic [7:0]  start_angle_q;
	logic [6:0]  object_count_q;
	logic [15:0] prev_q, prev_prev_q;
	logic [7:0]  best_width_q;
	logic [15:0] best_distance_q;
	logic [7:0]  best_angle_q;

	logic        on;
	logic [15:0] diff_near, diff_far;
	logic        in_object_n;
	logic [7:0]  run_length_n, start_angle_n, best_width_n, best_angle_n;
	logic [6:0]  object_count_n;
	logic [15:0] best_distance_n;
	logic        has_rep, has_sum;

	// Absolute differences against the two previous readings
	assign diff_near = (distance >= prev_q) ? distance - prev_q : prev_q - distance;
	assign diff_far  = (distance >= prev_prev_q) ? distance - prev_prev_q
	                                             : prev_prev_q - distance;
	assign on = (distance < max_range_q) && (diff_near <= near_tol_q)
	            && (diff_far <= far_tol_q);

	// Advance run tracking and the narrowest object
	always_comb begin
		in_object_n     = in_object_q;
		run_length_n    = run_length_q;
		start_angle_n   = start_angle_q;
		object_count_n  = object_count_q;
		best_width_n    = best_width_q;
		best_distance_n = best_distance_q;
		best_angle_n    = best_angle_q;
		has_rep         = 1'b0;
		if (on) begin
			if (!in_object_q) begin
				in_object_n    = 1'b1;
				object_count_n = object_count_q + 7'd1;
				start_angle_n  = angle;
				run_length_n   = 8'd1;
			end else if (run_length_q < RUN_CAP) begin
				run_length_n = run_length_q + 8'd1;
			end
		end else if (in_object_q) begin
			if (run_length_q > min_run_q) begin
				has_rep = 1'b1;
				if (run_length_q < best_width_q) begin
					best_width_n    = run_length_q;
					best_distance_n = distance;
					best_angle_n    = start_angle_q + {1'b0, run_length_q[7:1]};
				end
			end else begin
				object_count_n = object_count_q - 7'd1;
			end
			in_object_n  = 1'b0;
			run_length_n = 8'd0;
		end
		has_sum = end_of_sweep && (best_width_n < SweepW);
	end

	// Build the work entry for the back end
	always_comb begin
		work.has_rep      = has_rep;
		work.has_sum      = has_sum;
		work.rep_number   = object_count_q;
		work.rep_angle    = start_angle_q;
		work.rep_distance = prev_q;
		work.rep_width    = run_length_q + 8'd1;
		work.sum_angle    = best_angle_n;
		work.sum_distance = best_distance_n;
		work.sum_width    = best_width_n + 8'd1;
	end

	assign push = accept && (has_rep || has_sum);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= MAX_RANGE_RST;
			near_tol_q  <= NEAR_TOL_RST;
			far_tol_q   <= FAR_TOL_RST;
			min_run_q   <= MIN_RUN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_RANGE: max_range_q <= cfg_data;
				REG_NEAR_TOL:  near_tol_q  <= cfg_data;
				REG_FAR_TOL:   far_tol_q   <= cfg_data;
				REG_MIN_RUN:   min_run_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sweep state; clear on the end-of-sweep beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_object_q     <= 1'b0;
			run_length_q    <= 8'd0;
			start_angle_q   <= 8'd0;
			object_count_q  <= 7'd0;
			prev_q          <= MAX_RANGE_RST;
			prev_prev_q     <= MAX_RANGE_RST;
			best_width_q    <= SweepW;
			best_distance_q <= MAX_RANGE_RST;
			best_angle_q    <= 8'd0;
		end else if (accept) begin
			if (end_of_sweep) begin
				in_object_q     <= 1'b0;
				run_length_q    <= 8'd0;
				start_angle_q   <= 8'd0;
				object_count_q  <= 7'd0;
				prev_q          <= max_range_q;
				prev_prev_q     <= max_range_q;
				best_width_q    <= SweepW;
				best_distance_q <= max_range_q;
				best_angle_q    <= 8'd0;
			end else begin
				in_object_q     <= in_object_n;
				run_length_q    <= run_length_n;
				start_angle_q   <= start_angle_n;
				object_count_q  <= object_count_n;
				prev_q          <= distance;
				prev_prev_q     <= prev_q;
				best_width_q    <= best_width_n;
				best_distance_q <= best_distance_n;
				best_angle_q    <= best_angle_n;
			end
		end
	end

endmodule

### sv/sos_queue.sv
// Short work queue between the front and back ends.
module sos_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sos_pkg::work_t  wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output sos_pkg::work_t  head
);
	import sos_pkg::*;

	work_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full     = (count_q == (QAW+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

endmodule

### sv/sos_back.sv
// Back end: splits queued work into result beats behind an output register.
module sos_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sos_pkg::work_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            kind,
	output logic [6:0]      object_number,
	output logic [7:0]      report_angle,
	output logic [15:0]     report_distance,
	output logic [7:0]      width,
	output logic            last
);
	import sos_pkg::*;

	logic out_valid_q;
	logic phase_q;
	logic load, emit_rep;

	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign emit_rep = head.has_rep && !phase_q;
	assign pop      = load && !(emit_rep && head.has_sum);
	assign out_valid = out_valid_q;

	// Track valid and which half of a two-result entry goes next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !pop;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_rep) begin
				kind            <= KIND_OBJECT;
				object_number   <= head.rep_number;
				report_angle    <= head.rep_angle;
				report_distance <= head.rep_distance;
				width           <= head.rep_width;
				last            <= !head.has_sum;
			end else begin
				kind            <= KIND_SUMMARY;
				object_number   <= 7'd0;
				report_angle    <= head.sum_angle;
				report_distance <= head.sum_distance;
				width           <= head.sum_width;
				last            <= 1'b1;
			end
		end
	end

endmodule

### sv/sweep_object_segmenter_core.sv
// Top level of the sweep object segmenter.
//
//  channel  direction  handshake          payload
//  input    in         in_valid/in_stall  distance, angle, end_of_sweep
//  result   out        out_valid/out_stall kind, object_number, report_angle,
//                                          report_distance, width, last
//  config   in         cfg_we             cfg_index, cfg_data
//
// One reading is accepted per cycle while the queue is not full; the front end
// classifies it and updates the sweep state in the cycle of acceptance.
// A reading that causes two results is sent as two result beats; a four-entry queue
// absorbs bursts. in_stall rises only when the queue is full; a beat leaves the queue
// at the edge that loads the output register, so with an empty queue a reading passes
// the queue and then the output register before out_valid rises. Reset loads register
// defaults and clears state.
module sweep_object_segmenter_core #(
	parameter int SWEEP_POINTS = 181
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] distance,
	input  logic [7:0]  angle,
	input  logic        end_of_sweep,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [6:0]  object_number,
	output logic [7:0]  report_angle,
	output logic [15:0] report_distance,
	output logic [7:0]  width,
	output logic        last
);
	import sos_pkg::*;

	logic  accept, push, full, pop, head_valid;
	work_t work, head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	sos_front #(
		.SWEEP_POINTS(SWEEP_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.distance     (distance),
		.angle        (angle),
		.end_of_sweep (end_of_sweep),
		.push         (push),
		.work         (work)
	);

	sos_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (work),
		.full     (full),
		.pop      (pop),
		.nonempty (head_valid),
		.head     (head)
	);

	sos_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.object_number   (object_number),
		.report_angle    (report_angle),
		.report_distance (report_distance),
		.width           (width),
		.last            (last)
	);

endmodule
